// ===== hdl/spherical_panorama_ray_direction_macros.svh =====
// Assertion macros for the spherical panorama ray direction block.
`ifndef SPHERICAL_PANORAMA_RAY_DIRECTION_MACROS_SVH
`define SPHERICAL_PANORAMA_RAY_DIRECTION_MACROS_SVH

// same-cycle implication
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srd_pkg.sv =====
// Shared types, constants and tables for the spherical panorama ray direction block.
`default_nettype none
package srd_pkg;

  localparam int CORDIC_STAGES_DEF = 20;

  localparam int SAMPLE_W = 32;
  localparam int NUM_W    = 57;
  localparam int PRODN_W  = 48;
  localparam int DEN_W    = 37;
  localparam int QM_W     = 25;
  localparam int LAM_W    = 26;
  localparam int ANG_W    = 28;
  localparam int CX_W     = 34;
  localparam int SC_W     = 22;
  localparam int PROD_W   = 23;
  localparam int MUL_W    = 44;
  localparam int SUM_W    = 46;
  localparam int RND_W    = 27;
  localparam int VEC_W    = 21;
  localparam int BASIS_W  = 63;
  localparam int RES_W    = 13;
  localparam int PIX_W    = 24;
  localparam int AMAX_W   = 17;
  localparam int IDX_W    = 3;

  localparam logic [QM_W-1:0]         DEG_360  = 25'd23592960;
  localparam logic signed [ANG_W-1:0] DEG_360S = 28'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG_180  = 28'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_90   = 28'sd5898240;
  localparam logic signed [CX_W-1:0]  CORDIC_K = 34'sd652032874;

  localparam logic signed [VEC_W-1:0] DIR_MAX = 21'sd1048575;
  localparam logic signed [VEC_W-1:0] DIR_MIN = -21'sd1048576;

  localparam logic [IDX_W-1:0] REG_HRES    = 3'd0;
  localparam logic [IDX_W-1:0] REG_VRES    = 3'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_AZM_MAX = 3'd3;
  localparam logic [IDX_W-1:0] REG_POL_MAX = 3'd4;
  localparam logic [IDX_W-1:0] REG_BASIS_U = 3'd5;
  localparam logic [IDX_W-1:0] REG_BASIS_V = 3'd6;
  localparam logic [IDX_W-1:0] REG_BASIS_W = 3'd7;

  localparam logic [RES_W-1:0]   HRES_RST    = 13'd400;
  localparam logic [RES_W-1:0]   VRES_RST    = 13'd400;
  localparam logic [PIX_W-1:0]   PIXEL_RST   = 24'd65536;
  localparam logic [AMAX_W-1:0]  AMAX_RST    = 17'd46080;
  localparam logic [BASIS_W-1:0] BASIS_U_RST = 63'd524288;
  localparam logic [BASIS_W-1:0] BASIS_V_RST = 63'd1099511627776;
  localparam logic [BASIS_W-1:0] BASIS_W_RST = 63'd2305843009213693952;

  // atan(2^-i) in degrees, Q.16
  localparam logic [21:0] ATAN_TAB [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QM_W-1:0]  qm;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    neg;
  } cordic_lane_t;

endpackage
`default_nettype wire

// ===== hdl/srd_div_cell.sv =====
// One quotient bit of the angle divider, with the quotient kept modulo 360 degrees.
`default_nettype none
module srd_div_cell (
  input  logic              clk,
  input  logic              en,
  input  srd_pkg::div_lane_t lane_i,
  output srd_pkg::div_lane_t lane_o
);

  logic [srd_pkg::DEN_W:0]  trial;
  logic [srd_pkg::DEN_W:0]  diff;
  logic                     fits;
  logic [srd_pkg::QM_W:0]   qm2;
  logic [srd_pkg::QM_W:0]   qm_sub;
  srd_pkg::div_lane_t       lane_nxt;
  srd_pkg::div_lane_t       lane_r;

  always_comb begin
    trial  = {lane_i.rem, lane_i.num[srd_pkg::NUM_W-1]};
    diff   = trial - {1'b0, lane_i.den};
    fits   = (trial >= {1'b0, lane_i.den});
    qm2    = {lane_i.qm, fits};
    qm_sub = qm2 - {1'b0, srd_pkg::DEG_360};
    lane_nxt.num = {lane_i.num[srd_pkg::NUM_W-2:0], 1'b0};
    lane_nxt.den = lane_i.den;
    lane_nxt.rem = fits ? diff[srd_pkg::DEN_W-1:0] : trial[srd_pkg::DEN_W-1:0];
    lane_nxt.qm  = (qm2 >= {1'b0, srd_pkg::DEG_360}) ? qm_sub[srd_pkg::QM_W-1:0]
                                                     : qm2[srd_pkg::QM_W-1:0];
    lane_nxt.neg = lane_i.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

// ===== hdl/srd_cordic_cell.sv =====
// One rotation step of the sine/cosine CORDIC.
`default_nettype none
module srd_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  srd_pkg::cordic_lane_t lane_i,
  output srd_pkg::cordic_lane_t lane_o
);

  logic signed [srd_pkg::CX_W-1:0]  dx;
  logic signed [srd_pkg::CX_W-1:0]  dy;
  logic signed [srd_pkg::ANG_W-1:0] at;
  srd_pkg::cordic_lane_t            lane_nxt;
  srd_pkg::cordic_lane_t            lane_r;

  always_comb begin
    dx = lane_i.y >>> IDX;
    dy = lane_i.x >>> IDX;
    at = signed'({6'd0, srd_pkg::ATAN_TAB[IDX]});
    lane_nxt.neg = lane_i.neg;
    if (lane_i.z >= 0) begin
      lane_nxt.x = lane_i.x - dx;
      lane_nxt.y = lane_i.y + dy;
      lane_nxt.z = lane_i.z - at;
    end else begin
      lane_nxt.x = lane_i.x + dx;
      lane_nxt.y = lane_i.y - dy;
      lane_nxt.z = lane_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

// ===== hdl/spherical_panorama_ray_direction.sv =====
// Top level: spherical panoramic camera ray direction pipeline.
//
//  channel | ports                               | role
//  in      | in_valid in_ready in_sample_x/y     | view-plane sample point
//  out     | out_valid out_ready out_dir_x/y/z   | ray direction, Q1.19
//  cfg     | cfg_we cfg_index cfg_data           | register writes
//
// One transaction is accepted per cycle while in_ready is high; pipeline depth is
// set by the 57-cell divider chain and the CORDIC_STAGES-cell rotation chain.
// All pipeline stages advance together; a two-entry output buffer decouples
// out_ready, so in_ready drops only when that buffer is full.
// Reset is synchronous and clears valid bits and buffer count; config registers load defaults.
`default_nettype none
`include "spherical_panorama_ray_direction_macros.svh"
module spherical_panorama_ray_direction #(
  parameter int CORDIC_STAGES = srd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [srd_pkg::SAMPLE_W-1:0] in_sample_x,
  input  logic signed [srd_pkg::SAMPLE_W-1:0] in_sample_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [srd_pkg::VEC_W-1:0]    out_dir_x,
  output logic signed [srd_pkg::VEC_W-1:0]    out_dir_y,
  output logic signed [srd_pkg::VEC_W-1:0]    out_dir_z,
  input  logic                                cfg_we,
  input  logic [srd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [srd_pkg::BASIS_W-1:0]         cfg_data
);

  localparam int PIPE_LEN = CORDIC_STAGES + srd_pkg::NUM_W + 6;

  // configuration
  logic [srd_pkg::RES_W-1:0]   hres_r, vres_r;
  logic [srd_pkg::PIX_W-1:0]   pix_r;
  logic [srd_pkg::AMAX_W-1:0]  azm_r, pol_r;
  logic [srd_pkg::BASIS_W-1:0] bu_r, bv_r, bw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hres_r <= srd_pkg::HRES_RST;
      vres_r <= srd_pkg::VRES_RST;
      pix_r  <= srd_pkg::PIXEL_RST;
      azm_r  <= srd_pkg::AMAX_RST;
      pol_r  <= srd_pkg::AMAX_RST;
      bu_r   <= srd_pkg::BASIS_U_RST;
      bv_r   <= srd_pkg::BASIS_V_RST;
      bw_r   <= srd_pkg::BASIS_W_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srd_pkg::REG_HRES:    hres_r <= cfg_data[srd_pkg::RES_W-1:0];
        srd_pkg::REG_VRES:    vres_r <= cfg_data[srd_pkg::RES_W-1:0];
        srd_pkg::REG_PIXEL:   pix_r  <= cfg_data[srd_pkg::PIX_W-1:0];
        srd_pkg::REG_AZM_MAX: azm_r  <= cfg_data[srd_pkg::AMAX_W-1:0];
        srd_pkg::REG_POL_MAX: pol_r  <= cfg_data[srd_pkg::AMAX_W-1:0];
        srd_pkg::REG_BASIS_U: bu_r   <= cfg_data;
        srd_pkg::REG_BASIS_V: bv_r   <= cfg_data;
        srd_pkg::REG_BASIS_W: bw_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                 en;
  logic [PIPE_LEN-1:0]  vld_r;
  logic [1:0]           cnt_r;
  logic                 push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;
  assign push     = en && vld_r[PIPE_LEN-1];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_valid};
    end
  end

  // stage 1: numerator and divisor products
  logic [srd_pkg::SAMPLE_W-1:0] mag_x, mag_y;
  logic [48:0]                  numx_full, numy_full;
  logic [srd_pkg::DEN_W-1:0]    denx, deny;
  logic [srd_pkg::PRODN_W-1:0]  p1_numx_r, p1_numy_r;
  logic [srd_pkg::DEN_W-1:0]    p1_denx_r, p1_deny_r;
  logic                         p1_negx_r, p1_negy_r;

  always_comb begin
    mag_x     = in_sample_x[srd_pkg::SAMPLE_W-1] ? 32'(-in_sample_x) : 32'(in_sample_x);
    mag_y     = in_sample_y[srd_pkg::SAMPLE_W-1] ? 32'(-in_sample_y) : 32'(in_sample_y);
    numx_full = 49'(mag_x) * 49'(azm_r);
    numy_full = 49'(mag_y) * 49'(pol_r);
    denx      = 37'(pix_r) * 37'(hres_r);
    deny      = 37'(pix_r) * 37'(vres_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_numx_r <= numx_full[srd_pkg::PRODN_W-1:0];
      p1_numy_r <= numy_full[srd_pkg::PRODN_W-1:0];
      p1_denx_r <= (denx == '0) ? 37'd1 : denx;
      p1_deny_r <= (deny == '0) ? 37'd1 : deny;
      p1_negx_r <= in_sample_x[srd_pkg::SAMPLE_W-1];
      p1_negy_r <= in_sample_y[srd_pkg::SAMPLE_W-1];
    end
  end

  // divider chains
  srd_pkg::div_lane_t div_x [srd_pkg::NUM_W+1];
  srd_pkg::div_lane_t div_y [srd_pkg::NUM_W+1];

  always_comb begin
    div_x[0].num = {p1_numx_r, 9'd0};
    div_x[0].den = p1_denx_r;
    div_x[0].rem = '0;
    div_x[0].qm  = '0;
    div_x[0].neg = p1_negx_r;
    div_y[0].num = {p1_numy_r, 9'd0};
    div_y[0].den = p1_deny_r;
    div_y[0].rem = '0;
    div_y[0].qm  = '0;
    div_y[0].neg = p1_negy_r;
  end

  for (genvar k = 0; k < srd_pkg::NUM_W; k++) begin : g_div
    srd_div_cell u_div_x (.clk(clk), .en(en), .lane_i(div_x[k]), .lane_o(div_x[k+1]));
    srd_div_cell u_div_y (.clk(clk), .en(en), .lane_i(div_y[k]), .lane_o(div_y[k+1]));
  end

  // angle wrap and quadrant fold
  logic signed [srd_pkg::LAM_W-1:0] lam, psi;
  logic signed [srd_pkg::ANG_W-1:0] phi0, phi1, th0, th1;
  srd_pkg::cordic_lane_t            cor_p [CORDIC_STAGES+1];
  srd_pkg::cordic_lane_t            cor_t [CORDIC_STAGES+1];
  srd_pkg::cordic_lane_t            w_phi_nxt, w_th_nxt, w_phi_r, w_th_r;

  always_comb begin
    lam  = div_x[srd_pkg::NUM_W].neg ? -26'(div_x[srd_pkg::NUM_W].qm)
                                     : 26'(div_x[srd_pkg::NUM_W].qm);
    psi  = div_y[srd_pkg::NUM_W].neg ? -26'(div_y[srd_pkg::NUM_W].qm)
                                     : 26'(div_y[srd_pkg::NUM_W].qm);
    phi0 = srd_pkg::DEG_180 - 28'(lam);
    th0  = srd_pkg::DEG_90 - 28'(psi);
    if (phi0 >= srd_pkg::DEG_180) phi1 = phi0 - srd_pkg::DEG_360S;
    else if (phi0 < -srd_pkg::DEG_180) phi1 = phi0 + srd_pkg::DEG_360S;
    else phi1 = phi0;
    if (th0 >= srd_pkg::DEG_180) th1 = th0 - srd_pkg::DEG_360S;
    else if (th0 < -srd_pkg::DEG_180) th1 = th0 + srd_pkg::DEG_360S;
    else th1 = th0;
    w_phi_nxt.x = srd_pkg::CORDIC_K;
    w_phi_nxt.y = '0;
    w_th_nxt.x  = srd_pkg::CORDIC_K;
    w_th_nxt.y  = '0;
    if (phi1 > srd_pkg::DEG_90) begin
      w_phi_nxt.z = phi1 - srd_pkg::DEG_180;
      w_phi_nxt.neg = 1'b1;
    end else if (phi1 < -srd_pkg::DEG_90) begin
      w_phi_nxt.z = phi1 + srd_pkg::DEG_180;
      w_phi_nxt.neg = 1'b1;
    end else begin
      w_phi_nxt.z = phi1;
      w_phi_nxt.neg = 1'b0;
    end
    if (th1 > srd_pkg::DEG_90) begin
      w_th_nxt.z = th1 - srd_pkg::DEG_180;
      w_th_nxt.neg = 1'b1;
    end else if (th1 < -srd_pkg::DEG_90) begin
      w_th_nxt.z = th1 + srd_pkg::DEG_180;
      w_th_nxt.neg = 1'b1;
    end else begin
      w_th_nxt.z = th1;
      w_th_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_phi_r <= w_phi_nxt;
      w_th_r  <= w_th_nxt;
    end
  end

  assign cor_p[0] = w_phi_r;
  assign cor_t[0] = w_th_r;

  // CORDIC chains
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
    srd_cordic_cell #(.IDX(i)) u_cor_p (
      .clk(clk), .en(en), .lane_i(cor_p[i]), .lane_o(cor_p[i+1])
    );
    srd_cordic_cell #(.IDX(i)) u_cor_t (
      .clk(clk), .en(en), .lane_i(cor_t[i]), .lane_o(cor_t[i+1])
    );
  end

  // round sin/cos to Q1.19
  logic signed [srd_pkg::CX_W-1:0] sp_f, cp_f, st_f, ct_f;
  logic signed [srd_pkg::CX_W-1:0] sp_s, cp_s, st_s, ct_s;
  logic signed [srd_pkg::SC_W-1:0] sp_r, cp_r, st_r, ct_r;

  always_comb begin
    sp_f = cor_p[CORDIC_STAGES].neg ? -cor_p[CORDIC_STAGES].y : cor_p[CORDIC_STAGES].y;
    cp_f = cor_p[CORDIC_STAGES].neg ? -cor_p[CORDIC_STAGES].x : cor_p[CORDIC_STAGES].x;
    st_f = cor_t[CORDIC_STAGES].neg ? -cor_t[CORDIC_STAGES].y : cor_t[CORDIC_STAGES].y;
    ct_f = cor_t[CORDIC_STAGES].neg ? -cor_t[CORDIC_STAGES].x : cor_t[CORDIC_STAGES].x;
    sp_s = (sp_f + 34'sd1024) >>> 11;
    cp_s = (cp_f + 34'sd1024) >>> 11;
    st_s = (st_f + 34'sd1024) >>> 11;
    ct_s = (ct_f + 34'sd1024) >>> 11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r <= sp_s[srd_pkg::SC_W-1:0];
      cp_r <= cp_s[srd_pkg::SC_W-1:0];
      st_r <= st_s[srd_pkg::SC_W-1:0];
      ct_r <= ct_s[srd_pkg::SC_W-1:0];
    end
  end

  // sin(theta) products
  logic signed [srd_pkg::MUL_W-1:0]  pa_nxt, pc_nxt, pa_r, pc_r;
  logic signed [srd_pkg::MUL_W-1:0]  pa_s, pc_s;
  logic signed [srd_pkg::SC_W-1:0]   ct1_r, ct2_r;
  logic signed [srd_pkg::PROD_W-1:0] a_r, c_r;

  assign pa_nxt = st_r * sp_r;
  assign pc_nxt = st_r * cp_r;
  assign pa_s   = (pa_r + 44'sd262144) >>> 19;
  assign pc_s   = (pc_r + 44'sd262144) >>> 19;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pc_r  <= pc_nxt;
      ct1_r <= ct_r;
      a_r   <= pa_s[srd_pkg::PROD_W-1:0];
      c_r   <= pc_s[srd_pkg::PROD_W-1:0];
      ct2_r <= ct1_r;
    end
  end

  // basis products and component sums
  logic signed [srd_pkg::VEC_W-1:0] res [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [srd_pkg::VEC_W-1:0] uk, vk, wk;
    logic signed [srd_pkg::MUL_W-1:0] mu_r, mv_r, mw_r;
    logic signed [srd_pkg::SUM_W-1:0] sum;
    logic signed [srd_pkg::SUM_W-1:0] rnd;
    logic signed [srd_pkg::RND_W-1:0] rt;

    assign uk = bu_r[srd_pkg::VEC_W*k +: srd_pkg::VEC_W];
    assign vk = bv_r[srd_pkg::VEC_W*k +: srd_pkg::VEC_W];
    assign wk = bw_r[srd_pkg::VEC_W*k +: srd_pkg::VEC_W];

    always_ff @(posedge clk) begin
      if (en) begin
        mu_r <= a_r * uk;
        mv_r <= ct2_r * vk;
        mw_r <= c_r * wk;
      end
    end

    always_comb begin
      sum = 46'(mu_r) + 46'(mv_r) + 46'(mw_r);
      rnd = (sum + 46'sd262144) >>> 19;
      rt  = rnd[srd_pkg::RND_W-1:0];
      if (rt > 27'(srd_pkg::DIR_MAX)) res[k] = srd_pkg::DIR_MAX;
      else if (rt < 27'(srd_pkg::DIR_MIN)) res[k] = srd_pkg::DIR_MIN;
      else res[k] = rt[srd_pkg::VEC_W-1:0];
    end
  end

  // two-entry output buffer
  logic signed [srd_pkg::VEC_W-1:0] s0x_r, s0y_r, s0z_r, s1x_r, s1y_r, s1z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      s0x_r <= res[0];
      s0y_r <= res[1];
      s0z_r <= res[2];
    end else if (pop) begin
      s0x_r <= s1x_r;
      s0y_r <= s1y_r;
      s0z_r <= s1z_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        s0x_r <= res[0];
        s0y_r <= res[1];
        s0z_r <= res[2];
      end else begin
        s1x_r <= res[0];
        s1y_r <= res[1];
        s1z_r <= res[2];
      end
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_dir_x = s0x_r;
  assign out_dir_y = s0y_r;
  assign out_dir_z = s0z_r;

  `SRD_ASSERT_NOW(a_no_overflow, push, cnt_r != 2'd2, "push into full output buffer")
  `SRD_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "count did not rise")
  `SRD_ASSERT_NEXT(a_vld_enter, in_valid && in_ready, vld_r[0], "accepted item lost")

endmodule
`default_nettype wire
